// ----- hw/rtl/approx_subset_sum_trim_assert.svh -----
// Assertion macros used by the datapath module.
`ifndef APPROX_SUBSET_SUM_TRIM_ASSERT_SVH
`define APPROX_SUBSET_SUM_TRIM_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define ASST_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASST_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/asst_pkg.sv -----
// ----------------------------------------------------------------------------
// asst_pkg
// Shared constants and controller/datapath types of the subset sum trimmer.
// ----------------------------------------------------------------------------
package asst_pkg;

   localparam int MAX_ITEMS_DEF = 64;
   localparam int MAX_SUMS_DEF  = 1024;

   localparam int NUM_W      = 31;
   localparam int EPS_W      = 20;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [NUM_W-1:0] TARGET_RESET = '0;
   localparam logic [EPS_W-1:0] EPS_RESET    = 20'd6554;

   // register index, taken from paddr[2]
   localparam logic CSR_TARGET = 1'b0;
   localparam logic CSR_EPS    = 1'b1;

   typedef struct packed {
      logic load_item;
      logic k_dec;
      logic set_pos;
      logic sh_wr;
      logic ins_wr;
      logic init;
      logic store_rd_t;
      logic t_load;
      logic m_cmp;
      logic m_mul;
      logic m_keep;
      logic t_end;
      logic finish;
   } asst_cmd_type;

   typedef struct packed {
      logic full;
      logic k_zero;
      logic k_eq_pos;
      logic scan_eq;
      logic scan_lt;
      logic last;
      logic t_done;
      logic pair_none;
      logic dlen_zero;
      logic rsp_busy;
   } asst_status_type;

endpackage

// ----- hw/rtl/asst_ifs.sv -----
// ----------------------------------------------------------------------------
// asst_ifs
// Valid/ready channels for the number stream and the result.
// ----------------------------------------------------------------------------
interface asst_req_if import asst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] number;
   logic             last;
   modport source (output valid, number, last, input ready);
   modport sink (input valid, number, last, output ready);
endinterface

interface asst_rsp_if import asst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] best_sum;
   logic             list_overflow;
   modport source (output valid, best_sum, list_overflow, input ready);
   modport sink (input valid, best_sum, list_overflow, output ready);
endinterface

// ----- hw/rtl/asst_ctrl.sv -----
// ----------------------------------------------------------------------------
// asst_ctrl
// Sequencer: sorted insertion of each number, then the merge and trim passes.
// ----------------------------------------------------------------------------
module asst_ctrl import asst_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_fire,
   input  asst_status_type status,
   output asst_cmd_type    cmd,
   output logic            req_ready
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_CMP = 4'd2;
   localparam logic [3:0] S_SH_RD    = 4'd3;
   localparam logic [3:0] S_SH_WR    = 4'd4;
   localparam logic [3:0] S_INS      = 4'd5;
   localparam logic [3:0] S_POST     = 4'd6;
   localparam logic [3:0] S_INIT     = 4'd7;
   localparam logic [3:0] S_T_RD     = 4'd8;
   localparam logic [3:0] S_T_LOAD   = 4'd9;
   localparam logic [3:0] S_M_RD     = 4'd10;
   localparam logic [3:0] S_M_CMP    = 4'd11;
   localparam logic [3:0] S_M_MUL    = 4'd12;
   localparam logic [3:0] S_M_KEEP   = 4'd13;
   localparam logic [3:0] S_T_END    = 4'd14;
   localparam logic [3:0] S_FINISH   = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load_item = 1'b1;
               state_in      = status.full ? S_POST : S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (status.k_zero) begin
               cmd.set_pos = 1'b1;
               state_in    = S_SH_RD;
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (status.scan_eq) begin
               state_in = S_POST;
            end else if (status.scan_lt) begin
               cmd.set_pos = 1'b1;
               state_in    = S_SH_RD;
            end else begin
               cmd.k_dec = 1'b1;
               state_in  = S_SCAN_RD;
            end
         end
         S_SH_RD: begin
            state_in = status.k_eq_pos ? S_INS : S_SH_WR;
         end
         S_SH_WR: begin
            cmd.sh_wr = 1'b1;
            cmd.k_dec = 1'b1;
            state_in  = S_SH_RD;
         end
         S_INS: begin
            cmd.ins_wr = 1'b1;
            state_in   = S_POST;
         end
         S_POST: begin
            state_in = status.last ? S_INIT : S_IDLE;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_T_RD;
         end
         S_T_RD: begin
            cmd.store_rd_t = 1'b1;
            state_in       = status.t_done ? S_FINISH : S_T_LOAD;
         end
         S_T_LOAD: begin
            cmd.t_load = 1'b1;
            state_in   = S_M_RD;
         end
         S_M_RD: begin
            state_in = S_M_CMP;
         end
         S_M_CMP: begin
            if (status.pair_none) begin
               state_in = S_T_END;
            end else begin
               cmd.m_cmp = 1'b1;
               state_in  = status.dlen_zero ? S_M_RD : S_M_MUL;
            end
         end
         S_M_MUL: begin
            cmd.m_mul = 1'b1;
            state_in  = S_M_KEEP;
         end
         S_M_KEEP: begin
            cmd.m_keep = 1'b1;
            state_in   = S_M_RD;
         end
         S_T_END: begin
            cmd.t_end = 1'b1;
            state_in  = S_T_RD;
         end
         S_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/asst_dp.sv -----
// ----------------------------------------------------------------------------
// asst_dp
// Datapath: sorted number store, ping-pong sum lists, trim multipliers and
// the result register.
// ----------------------------------------------------------------------------
`include "approx_subset_sum_trim_assert.svh"

module asst_dp import asst_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF,
   parameter int MAX_SUMS  = MAX_SUMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  asst_cmd_type     cmd,
   output asst_status_type  status,
   input  logic [NUM_W-1:0] req_number,
   input  logic             req_last,
   input  logic [NUM_W-1:0] target_sum,
   input  logic [EPS_W-1:0] epsilon_q16,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [NUM_W-1:0] rsp_best_sum,
   output logic             rsp_list_overflow
);

   localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int SW  = $clog2(MAX_SUMS);
   localparam int LW  = SW + 1;
   localparam int SCW = CW + 17;
   localparam int FW  = ((SCW > EPS_W) ? SCW : EPS_W) + 1;
   localparam int PW  = FW + NUM_W;

   // number store
   logic [NUM_W-1:0] store_ff [MAX_ITEMS];
   logic [NUM_W-1:0] store_rd_ff;
   logic [CW-1:0]    store_raddr;
   logic             store_we;
   logic [CW-1:0]    store_waddr;
   logic [NUM_W-1:0] store_wdata;

   logic [NUM_W-1:0] num_ff;
   logic             last_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    k_ff;
   logic [CW-1:0]    pos_ff;
   logic [CW-1:0]    t_ff;
   logic [NUM_W-1:0] x_ff;

   // sum lists
   logic [NUM_W-1:0] sum_a_ff [MAX_SUMS];
   logic [NUM_W-1:0] sum_b_ff [MAX_SUMS];
   logic [NUM_W-1:0] a_rd_i_ff, a_rd_j_ff, b_rd_i_ff, b_rd_j_ff;
   logic             sel_ff;
   logic [LW-1:0]    i_ff, j_ff, len_ff, dlen_ff;
   logic             sum_we;
   logic             sum_to_a;
   logic [SW-1:0]    sum_waddr;
   logic [NUM_W-1:0] sum_wdata;

   logic [NUM_W-1:0] src_i, src_j;
   logic [NUM_W:0]   vj;
   logic             have_i, have_j, take_i;
   logic [NUM_W-1:0] v_sel;

   logic [NUM_W-1:0] v_ff;
   logic             take_i_ff;
   logic [NUM_W-1:0] a_ff;
   logic [SCW-1:0]   scale;
   logic [FW-1:0]    fac;
   logic [PW-1:0]    p1_ff, p2_ff;
   logic             ovf_ff;
   logic             room;

   logic             rsp_valid_ff;
   logic [NUM_W-1:0] rsp_best_ff;
   logic             rsp_ovf_ff;

   assign store_raddr = cmd.store_rd_t ? t_ff : (k_ff - CW'(1));
   assign store_we    = cmd.sh_wr | cmd.ins_wr;
   assign store_waddr = cmd.sh_wr ? k_ff : pos_ff;
   assign store_wdata = cmd.sh_wr ? store_rd_ff : num_ff;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_waddr[IW-1:0]] <= store_wdata;
      end
      store_rd_ff <= store_ff[store_raddr[IW-1:0]];
   end

   assign src_i  = sel_ff ? b_rd_i_ff : a_rd_i_ff;
   assign src_j  = sel_ff ? b_rd_j_ff : a_rd_j_ff;
   assign vj     = {1'b0, src_j} + {1'b0, x_ff};
   assign have_i = (i_ff < len_ff);
   assign have_j = (j_ff < len_ff) && (vj <= {1'b0, target_sum});
   assign take_i = have_i && (!have_j || ({1'b0, src_i} <= vj));
   assign v_sel  = take_i ? src_i : vj[NUM_W-1:0];

   assign scale = {count_ff, 17'b0};
   assign fac   = FW'(scale) + FW'(epsilon_q16);
   assign room  = (dlen_ff < LW'(MAX_SUMS));

   always_comb begin
      sum_we    = 1'b0;
      sum_to_a  = sel_ff;
      sum_waddr = dlen_ff[SW-1:0];
      sum_wdata = v_ff;
      if (cmd.init) begin
         sum_we    = 1'b1;
         sum_to_a  = 1'b1;
         sum_waddr = '0;
         sum_wdata = '0;
      end else if (cmd.m_cmp && dlen_ff == '0) begin
         sum_we    = 1'b1;
         sum_wdata = v_sel;
      end else if (cmd.m_keep && p1_ff > p2_ff && room) begin
         sum_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we && sum_to_a) begin
         sum_a_ff[sum_waddr] <= sum_wdata;
      end
      if (sum_we && !sum_to_a) begin
         sum_b_ff[sum_waddr] <= sum_wdata;
      end
      a_rd_i_ff <= sum_a_ff[i_ff[SW-1:0]];
      a_rd_j_ff <= sum_a_ff[j_ff[SW-1:0]];
      b_rd_i_ff <= sum_b_ff[i_ff[SW-1:0]];
      b_rd_j_ff <= sum_b_ff[j_ff[SW-1:0]];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         num_ff <= req_number;
         last_ff <= req_last;
      end
      if (cmd.set_pos) begin
         pos_ff <= k_ff;
      end
      if (cmd.t_load) begin
         x_ff <= store_rd_ff;
      end
      if (cmd.m_cmp) begin
         v_ff      <= v_sel;
         take_i_ff <= take_i;
      end
      if (cmd.m_cmp && dlen_ff == '0) begin
         a_ff <= v_sel;
      end else if (cmd.m_keep && p1_ff > p2_ff && room) begin
         a_ff <= v_ff;
      end
      if (cmd.m_mul) begin
         p1_ff <= PW'(scale) * PW'(v_ff);
         p2_ff <= PW'(a_ff) * PW'(fac);
      end
      if (cmd.finish) begin
         rsp_best_ff <= a_ff;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         k_ff         <= '0;
         t_ff         <= '0;
         sel_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         len_ff       <= '0;
         dlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_item || cmd.set_pos) begin
            k_ff <= count_ff;
         end else if (cmd.k_dec) begin
            k_ff <= k_ff - CW'(1);
         end
         if (cmd.ins_wr) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.finish) begin
            count_ff <= '0;
         end
         if (cmd.init) begin
            sel_ff <= 1'b0;
            len_ff <= LW'(1);
            t_ff   <= '0;
         end else if (cmd.t_end) begin
            sel_ff <= ~sel_ff;
            len_ff <= dlen_ff;
            t_ff   <= t_ff + CW'(1);
         end
         if (cmd.t_load) begin
            i_ff    <= '0;
            j_ff    <= '0;
            dlen_ff <= '0;
         end else if (cmd.m_cmp && dlen_ff == '0) begin
            dlen_ff <= LW'(1);
            if (take_i) begin
               i_ff <= i_ff + LW'(1);
            end else begin
               j_ff <= j_ff + LW'(1);
            end
         end else if (cmd.m_keep) begin
            if (p1_ff > p2_ff && room) begin
               dlen_ff <= dlen_ff + LW'(1);
            end
            if (take_i_ff) begin
               i_ff <= i_ff + LW'(1);
            end else begin
               j_ff <= j_ff + LW'(1);
            end
         end
         if (cmd.m_keep && p1_ff > p2_ff && !room) begin
            ovf_ff <= 1'b1;
         end else if (cmd.finish) begin
            ovf_ff <= 1'b0;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status           = '0;
      status.full      = (count_ff == CW'(MAX_ITEMS));
      status.k_zero    = (k_ff == '0);
      status.k_eq_pos  = (k_ff == pos_ff);
      status.scan_eq   = (store_rd_ff == num_ff);
      status.scan_lt   = (store_rd_ff < num_ff);
      status.last      = last_ff;
      status.t_done    = (t_ff == count_ff);
      status.pair_none = !have_i && !have_j;
      status.dlen_zero = (dlen_ff == '0);
      status.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_sum      = rsp_best_ff;
   assign rsp_list_overflow = rsp_ovf_ff;

   `ASST_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(MAX_ITEMS), "number count above store depth")
   `ASST_ALWAYS(a_dlen_range, clock, reset, dlen_ff <= LW'(MAX_SUMS), "sum list length above depth")
   `ASST_IMPLIES(a_sum_bound, clock, reset, sum_we, sum_wdata <= target_sum, "kept sum exceeds target")
   `ASST_IMPLIES(a_ovf_full, clock, reset, cmd.m_keep && !room, dlen_ff == LW'(MAX_SUMS), "overflow while list has room")

endmodule

// ----- hw/rtl/approx_subset_sum_trim.sv -----
// ----------------------------------------------------------------------------
// approx_subset_sum_trim
// Approximate subset sum by list trimming, with an APB register port.
// ----------------------------------------------------------------------------
// Usage: set target_sum (0x0) and epsilon_q16 (0x4) over APB while idle, then
// stream numbers on req_chan. Each number is inserted into a sorted set of
// up to MAX_ITEMS distinct values; repeats and numbers beyond a full set are
// ignored. An insert scans the number store and then shifts it; the next
// number is taken only once the insert is done. The number flagged last
// starts the compute: one pass per stored number, each merging the current
// list with itself plus that number. Each merged sum is read, compared,
// multiplied and trim tested; the first sum of a pass is only read and
// compared. One result per job on rsp_chan: best_sum and list_overflow.
// The result sits in an output register; a stalled receiver holds it, and
// the block keeps taking numbers meanwhile, waiting only if a second result
// is ready first. Reset clears the set, the lists and the result and loads
// register defaults (target_sum 0, epsilon_q16 6554). After a result the set
// empties.
// ----------------------------------------------------------------------------
module approx_subset_sum_trim import asst_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF,
   parameter int MAX_SUMS  = MAX_SUMS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   asst_req_if.sink              req_chan,
   asst_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   asst_cmd_type     cmd;
   asst_status_type  status;
   logic             req_ready;
   logic             csr_write;
   logic [NUM_W-1:0] target_ff;
   logic [EPS_W-1:0] eps_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         eps_ff    <= EPS_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_TARGET: target_ff <= pwdata[NUM_W-1:0];
            CSR_EPS:    eps_ff    <= pwdata[EPS_W-1:0];
            default:    target_ff <= target_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_TARGET: prdata = CSR_DATA_W'(target_ff);
         CSR_EPS:    prdata = CSR_DATA_W'(eps_ff);
         default:    prdata = '0;
      endcase
   end

   assign req_chan.ready = req_ready;

   asst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_chan.valid && req_ready),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   asst_dp #(
      .MAX_ITEMS (MAX_ITEMS),
      .MAX_SUMS  (MAX_SUMS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_number        (req_chan.number),
      .req_last          (req_chan.last),
      .target_sum        (target_ff),
      .epsilon_q16       (eps_ff),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_best_sum      (rsp_chan.best_sum),
      .rsp_list_overflow (rsp_chan.list_overflow)
   );

endmodule
